@@ design/prt_pkg.sv @@
// Shared types and constants for the process region table.
// Used by prt_ctrl, prt_dp and process_region_table_core; depends on nothing.
package prt_pkg;

  // Table geometry.
  localparam int MAX_OWNERS  = 64;
  localparam int MAX_REGIONS = 128;
  localparam int OWN_IW      = $clog2(MAX_OWNERS);
  localparam int OCNT_W      = $clog2(MAX_OWNERS + 1);
  localparam int REG_IW      = $clog2(MAX_REGIONS);
  localparam int RCNT_W      = $clog2(MAX_REGIONS + 1);
  localparam int ADDR_W      = 32;

  // Memory words: an owner entry is {id, count, row}, a region entry is
  // {base, size, creator}.
  localparam int OWN_DW = 32 + RCNT_W + OWN_IW;
  localparam int REG_DW = 3 * 32;
  localparam int REG_AW = OWN_IW + REG_IW;

  // Page arithmetic for the stack range check.
  localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hFFFF_F000;
  localparam logic [ADDR_W-1:0] PAGE_SIZE = 32'h0000_1000;

  typedef enum logic [1:0] {
    OP_INSERT       = 2'd0,
    OP_QUERY        = 2'd1,
    OP_REMOVE_OWNER = 2'd2,
    OP_REMOVE_STACK = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FO_RD,
    ST_FO_CMP,
    ST_NEW_WR,
    ST_APPEND,
    ST_RS_RD,
    ST_RS_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_OSH_RD,
    ST_OSH_WR,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    ORD_NONE,
    ORD_OI,
    ORD_OI1
  } own_rd_t;

  typedef enum logic [2:0] {
    OWR_NONE,
    OWR_NEW,
    OWR_CNT_INC,
    OWR_CNT_DEC,
    OWR_SHIFT,
    OWR_PARK
  } own_wr_t;

  typedef enum logic [1:0] {
    RRD_NONE,
    RRD_RI,
    RRD_RI1
  } reg_rd_t;

  typedef enum logic [1:0] {
    RWR_NONE,
    RWR_NEW,
    RWR_APPEND,
    RWR_SHIFT
  } reg_wr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    oi_clr;
    logic    oi_inc;
    logic    ri_clr;
    logic    ri_inc;
    own_rd_t own_rd;
    own_wr_t own_wr;
    reg_rd_t reg_rd;
    reg_wr_t reg_wr;
    logic    latch_owner;
    logic    owner_inc;
    logic    owner_dec;
    logic    res_load;
    logic    res_val;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic oi_end;
    logic oi1_end;
    logic table_full;
    logic own_match;
    logic list_full;
    logic ri_end;
    logic ri1_end;
    logic reg_match;
    logic out_free;
  } status_t;

endpackage

@@ design/prt_ctrl.sv @@
// Sequencer of the process region table: owner search, region scan and compaction.
// Depends on prt_pkg; drives the command struct into prt_dp.
module prt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  prt_pkg::status_t st,
  output prt_pkg::cmd_t    cmd
);

  prt_pkg::state_t state, state_next;
  logic ok_q, ok_next;

  // State and pending result bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prt_pkg::ST_IDLE;
      ok_q  <= 1'b0;
    end else begin
      state <= state_next;
      ok_q  <= ok_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    ok_next    = ok_q;
    in_stall   = 1'b1;
    cmd        = '0;
    cmd.own_rd = prt_pkg::ORD_NONE;
    cmd.own_wr = prt_pkg::OWR_NONE;
    cmd.reg_rd = prt_pkg::RRD_NONE;
    cmd.reg_wr = prt_pkg::RWR_NONE;
    unique case (state)
      prt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.oi_clr  = 1'b1;
          state_next  = prt_pkg::ST_FO_RD;
        end
      end
      prt_pkg::ST_FO_RD: begin
        if (st.oi_end) begin
          if (st.op == prt_pkg::OP_INSERT && !st.table_full) begin
            cmd.own_rd = prt_pkg::ORD_OI;
            state_next = prt_pkg::ST_NEW_WR;
          end else begin
            ok_next    = 1'b0;
            state_next = prt_pkg::ST_RESULT;
          end
        end else begin
          cmd.own_rd = prt_pkg::ORD_OI;
          state_next = prt_pkg::ST_FO_CMP;
        end
      end
      prt_pkg::ST_FO_CMP: begin
        if (st.own_match) begin
          cmd.latch_owner = 1'b1;
          unique case (st.op)
            prt_pkg::OP_INSERT:       state_next = prt_pkg::ST_APPEND;
            prt_pkg::OP_REMOVE_OWNER: state_next = prt_pkg::ST_OSH_RD;
            default: begin
              cmd.ri_clr = 1'b1;
              state_next = prt_pkg::ST_RS_RD;
            end
          endcase
        end else begin
          cmd.oi_inc = 1'b1;
          state_next = prt_pkg::ST_FO_RD;
        end
      end
      prt_pkg::ST_NEW_WR: begin
        cmd.own_wr    = prt_pkg::OWR_NEW;
        cmd.reg_wr    = prt_pkg::RWR_NEW;
        cmd.owner_inc = 1'b1;
        ok_next       = 1'b1;
        state_next    = prt_pkg::ST_RESULT;
      end
      prt_pkg::ST_APPEND: begin
        if (st.list_full) begin
          ok_next = 1'b0;
        end else begin
          cmd.own_wr = prt_pkg::OWR_CNT_INC;
          cmd.reg_wr = prt_pkg::RWR_APPEND;
          ok_next    = 1'b1;
        end
        state_next = prt_pkg::ST_RESULT;
      end
      prt_pkg::ST_RS_RD: begin
        if (st.ri_end) begin
          ok_next    = 1'b0;
          state_next = prt_pkg::ST_RESULT;
        end else begin
          cmd.reg_rd = prt_pkg::RRD_RI;
          state_next = prt_pkg::ST_RS_CMP;
        end
      end
      prt_pkg::ST_RS_CMP: begin
        if (st.reg_match) begin
          if (st.op == prt_pkg::OP_QUERY) begin
            ok_next    = 1'b1;
            state_next = prt_pkg::ST_RESULT;
          end else begin
            state_next = prt_pkg::ST_SH_RD;
          end
        end else begin
          cmd.ri_inc = 1'b1;
          state_next = prt_pkg::ST_RS_RD;
        end
      end
      prt_pkg::ST_SH_RD: begin
        if (st.ri1_end) begin
          cmd.own_wr = prt_pkg::OWR_CNT_DEC;
          ok_next    = 1'b1;
          state_next = prt_pkg::ST_RESULT;
        end else begin
          cmd.reg_rd = prt_pkg::RRD_RI1;
          state_next = prt_pkg::ST_SH_WR;
        end
      end
      prt_pkg::ST_SH_WR: begin
        cmd.reg_wr = prt_pkg::RWR_SHIFT;
        cmd.ri_inc = 1'b1;
        state_next = prt_pkg::ST_SH_RD;
      end
      prt_pkg::ST_OSH_RD: begin
        if (st.oi1_end) begin
          cmd.own_wr    = prt_pkg::OWR_PARK;
          cmd.owner_dec = 1'b1;
          ok_next       = 1'b1;
          state_next    = prt_pkg::ST_RESULT;
        end else begin
          cmd.own_rd = prt_pkg::ORD_OI1;
          state_next = prt_pkg::ST_OSH_WR;
        end
      end
      prt_pkg::ST_OSH_WR: begin
        cmd.own_wr = prt_pkg::OWR_SHIFT;
        cmd.oi_inc = 1'b1;
        state_next = prt_pkg::ST_OSH_RD;
      end
      prt_pkg::ST_RESULT: begin
        cmd.res_load = 1'b1;
        cmd.res_val  = ok_q;
        if (st.out_free) begin
          state_next = prt_pkg::ST_IDLE;
        end
      end
      default: state_next = prt_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/prt_dp.sv @@
// Datapath of the process region table: request registers, owner and region memories,
// counters, comparators and the output register. Depends on prt_pkg.
module prt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  op,
  input  logic [prt_pkg::ADDR_W-1:0]  base,
  input  logic [prt_pkg::ADDR_W-1:0]  size,
  input  logic [31:0]                 owner_id,
  input  logic [31:0]                 creator_id,
  input  logic [prt_pkg::ADDR_W-1:0]  stack_ptr,
  input  logic [prt_pkg::ADDR_W-1:0]  stack_bottom,
  input  logic [prt_pkg::ADDR_W-1:0]  stack_span,
  input  prt_pkg::cmd_t               cmd,
  output prt_pkg::status_t            st,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        ok
);

  // Captured request.
  prt_pkg::op_t               op_q;
  logic [prt_pkg::ADDR_W-1:0] base_q, end_q, owner_q, creator_q, sp_q, bottom_q, span_q;
  logic [prt_pkg::ADDR_W-1:0] stack_hi, page, page_hi;

  // Table control.
  logic [prt_pkg::OCNT_W-1:0] owner_count, hwm, oi;
  logic [prt_pkg::RCNT_W-1:0] ri;
  logic [prt_pkg::OWN_IW-1:0] o_idx, o_row;
  logic [prt_pkg::RCNT_W-1:0] o_cnt;
  logic [31:0]                o_id;

  // Memories and their registered read ports.
  logic [prt_pkg::OWN_DW-1:0] own_mem [prt_pkg::MAX_OWNERS];
  logic [prt_pkg::REG_DW-1:0] reg_mem [prt_pkg::MAX_OWNERS * prt_pkg::MAX_REGIONS];
  logic [prt_pkg::OWN_DW-1:0] own_rd;
  logic [prt_pkg::REG_DW-1:0] reg_rd;
  logic [prt_pkg::OWN_IW-1:0] own_ra;

  logic [prt_pkg::OCNT_W-1:0] oi1;
  logic [prt_pkg::RCNT_W-1:0] ri1;
  logic [31:0]                rd_id;
  logic [prt_pkg::RCNT_W-1:0] rd_cnt;
  logic [prt_pkg::OWN_IW-1:0] rd_row, eff_row;
  logic [31:0]                rb, rs, rc, re;
  logic [31:0]                key;

  // Owner memory write port.
  logic                       own_we;
  logic [prt_pkg::OWN_IW-1:0] own_wa;
  logic [prt_pkg::OWN_DW-1:0] own_wd;

  // Region memory write port.
  logic                       reg_we;
  logic [prt_pkg::REG_AW-1:0] reg_wa;
  logic [prt_pkg::REG_DW-1:0] reg_wd;

  assign oi1     = oi + 1'b1;
  assign ri1     = ri + 1'b1;
  assign rd_id   = own_rd[prt_pkg::OWN_DW-1 -: 32];
  assign rd_cnt  = own_rd[prt_pkg::OWN_IW +: prt_pkg::RCNT_W];
  assign rd_row  = own_rd[prt_pkg::OWN_IW-1:0];
  // Slots at or above the high-water mark were never written and still map to their own row.
  assign eff_row = ({1'b0, own_ra} >= hwm) ? own_ra : rd_row;
  assign rb      = reg_rd[95:64];
  assign rs      = reg_rd[63:32];
  assign rc      = reg_rd[31:0];
  assign re      = rb + rs;
  assign key     = (op_q == prt_pkg::OP_REMOVE_OWNER) ? creator_q : owner_q;

  // Request capture and the derived stack bounds.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= prt_pkg::op_t'(op);
      base_q    <= base;
      end_q     <= base + size;
      owner_q   <= owner_id;
      creator_q <= creator_id;
      sp_q      <= stack_ptr;
      bottom_q  <= stack_bottom;
      span_q    <= stack_span;
      page      <= (stack_ptr & prt_pkg::PAGE_MASK) + (prt_pkg::PAGE_SIZE - stack_span);
    end
    stack_hi <= bottom_q + span_q;
    page_hi  <= page + span_q;
  end

  // Counters and the found owner.
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_count <= '0;
      hwm         <= '0;
    end else begin
      if (cmd.owner_inc) begin
        owner_count <= owner_count + 1'b1;
        if (owner_count == hwm) begin
          hwm <= hwm + 1'b1;
        end
      end else if (cmd.owner_dec) begin
        owner_count <= owner_count - 1'b1;
      end
    end
    if (cmd.oi_clr) begin
      oi <= '0;
    end else if (cmd.oi_inc) begin
      oi <= oi1;
    end
    if (cmd.ri_clr) begin
      ri <= '0;
    end else if (cmd.ri_inc) begin
      ri <= ri1;
    end
    if (cmd.latch_owner) begin
      o_idx <= own_ra;
      o_row <= eff_row;
      o_cnt <= rd_cnt;
      o_id  <= rd_id;
    end
  end

  // Owner memory write selection.
  always_comb begin
    own_we = 1'b1;
    own_wa = oi[prt_pkg::OWN_IW-1:0];
    own_wd = {rd_id, rd_cnt, eff_row};
    unique case (cmd.own_wr)
      prt_pkg::OWR_NONE:    own_we = 1'b0;
      prt_pkg::OWR_NEW:     own_wd = {owner_q, prt_pkg::RCNT_W'(1), eff_row};
      prt_pkg::OWR_CNT_INC: begin
        own_wa = o_idx;
        own_wd = {o_id, o_cnt + 1'b1, o_row};
      end
      prt_pkg::OWR_CNT_DEC: begin
        own_wa = o_idx;
        own_wd = {o_id, o_cnt - 1'b1, o_row};
      end
      prt_pkg::OWR_SHIFT:   own_wd = {rd_id, rd_cnt, eff_row};
      prt_pkg::OWR_PARK:    own_wd = {o_id, prt_pkg::RCNT_W'(0), o_row};
      default:              own_we = 1'b0;
    endcase
  end

  // Region memory write selection.
  always_comb begin
    reg_we = 1'b1;
    reg_wa = {o_row, ri[prt_pkg::REG_IW-1:0]};
    reg_wd = {base_q, end_q - base_q, creator_q};
    unique case (cmd.reg_wr)
      prt_pkg::RWR_NONE:   reg_we = 1'b0;
      prt_pkg::RWR_NEW:    reg_wa = {eff_row, prt_pkg::REG_IW'(0)};
      prt_pkg::RWR_APPEND: reg_wa = {o_row, o_cnt[prt_pkg::REG_IW-1:0]};
      prt_pkg::RWR_SHIFT:  reg_wd = reg_rd;
      default:             reg_we = 1'b0;
    endcase
  end

  // Owner memory.
  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
    if (cmd.own_rd == prt_pkg::ORD_OI) begin
      own_rd <= own_mem[oi[prt_pkg::OWN_IW-1:0]];
      own_ra <= oi[prt_pkg::OWN_IW-1:0];
    end else if (cmd.own_rd == prt_pkg::ORD_OI1) begin
      own_rd <= own_mem[oi1[prt_pkg::OWN_IW-1:0]];
      own_ra <= oi1[prt_pkg::OWN_IW-1:0];
    end
  end

  // Region memory.
  always_ff @(posedge clk) begin
    if (reg_we) begin
      reg_mem[reg_wa] <= reg_wd;
    end
    if (cmd.reg_rd == prt_pkg::RRD_RI) begin
      reg_rd <= reg_mem[{o_row, ri[prt_pkg::REG_IW-1:0]}];
    end else if (cmd.reg_rd == prt_pkg::RRD_RI1) begin
      reg_rd <= reg_mem[{o_row, ri1[prt_pkg::REG_IW-1:0]}];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load && st.out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.res_load && st.out_free) begin
      ok <= cmd.res_val;
    end
  end

  // Status back to the controller.
  always_comb begin
    st.op         = op_q;
    st.oi_end     = (oi == owner_count);
    st.oi1_end    = (oi1 == owner_count);
    st.table_full = (owner_count >= prt_pkg::OCNT_W'(prt_pkg::MAX_OWNERS));
    st.own_match  = (rd_id == key);
    st.list_full  = (o_cnt >= prt_pkg::RCNT_W'(prt_pkg::MAX_REGIONS));
    st.ri_end     = (ri == o_cnt);
    st.ri1_end    = (ri1 == o_cnt);
    if (op_q == prt_pkg::OP_QUERY) begin
      st.reg_match = (rc == creator_q) && (base_q >= rb) && (end_q <= re);
    end else begin
      st.reg_match = ((rb <= sp_q) && (re >= sp_q)) ||
                     ((rb < stack_hi) && (re > bottom_q)) ||
                     ((rb < page_hi) && (re > page));
    end
    st.out_free   = !out_valid || !out_stall;
  end

endmodule

@@ design/process_region_table_core.sv @@
// Process region table: up to 64 owners, each with a list of up to 128 regions.
// The sequencer steps the owner memory and then the region memory one entry at a time
// (search, scan and compaction each read an entry, then compare or write it); the worst
// case is an owner in the last slot followed by a full 128-region scan or scan and
// compaction. The result word is held while the output stays stalled. Removing an owner
// shifts only the 64-entry owner memory; region rows are remapped, not moved. No clearing
// pass is needed after reset. The block takes one request at a time.
// Depends on prt_pkg, prt_ctrl and prt_dp.
module process_region_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] base,
  input  logic [31:0] size,
  input  logic [31:0] owner_id,
  input  logic [31:0] creator_id,
  input  logic [31:0] stack_ptr,
  input  logic [31:0] stack_bottom,
  input  logic [31:0] stack_span,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok
);

  prt_pkg::cmd_t    cmd;
  prt_pkg::status_t st;

  // Sequencer.
  prt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Tables and compare logic.
  prt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .base         (base),
    .size         (size),
    .owner_id     (owner_id),
    .creator_id   (creator_id),
    .stack_ptr    (stack_ptr),
    .stack_bottom (stack_bottom),
    .stack_span   (stack_span),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok)
  );

  // An accepted word keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while a previous one still in work");

  // A loaded result appears on the output.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load && st.out_free |=> out_valid)
    else $error("result lost at the output register");

  // Memory writes never happen while the block is waiting for a request.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> (cmd.own_wr == prt_pkg::OWR_NONE) && (cmd.reg_wr == prt_pkg::RWR_NONE))
    else $error("table written while idle");

endmodule

@@ sim/process_region_table_core_tb.sv @@
// Testbench for process_region_table_core: drives table requests with random gaps and
// stalls, predicts each ok bit with a behavioral copy of the table, and checks in order.
// Depends on prt_pkg and the process_region_table_core RTL.
module process_region_table_core_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = prt_pkg::OP_INSERT;
  logic [31:0] base = '0, size = '0, owner_id = '0, creator_id = '0;
  logic [31:0] stack_ptr = '0, stack_bottom = '0, stack_span = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        ok;

  process_region_table_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One request word as the sender sees it.
  typedef struct {
    prt_pkg::op_t kind;
    logic [31:0]  rbase, rsize, owner, creator, sp, bottom, span;
    int           want;  // -1: take the predicted value
  } req_t;

  // Behavioral copy of the table.
  int          tbl_owners;
  logic [31:0] tbl_ids [prt_pkg::MAX_OWNERS];
  int          tbl_cnt [prt_pkg::MAX_OWNERS];
  logic [31:0] tbl_base [prt_pkg::MAX_OWNERS][prt_pkg::MAX_REGIONS];
  logic [31:0] tbl_size [prt_pkg::MAX_OWNERS][prt_pkg::MAX_REGIONS];
  logic [31:0] tbl_crea [prt_pkg::MAX_OWNERS][prt_pkg::MAX_REGIONS];

  logic expected_ok [$];
  int   mismatches = 0;
  int   long_hold = 0;
  bit   sender_done = 1'b0;

  task automatic report(input string what);
    $display("mismatch: %s at %0t", what, $time);
    mismatches++;
  endtask

  function automatic int owner_slot(input logic [31:0] id);
    for (int i = 0; i < tbl_owners; i++)
      if (tbl_ids[i] == id) return i;
    return -1;
  endfunction

  // Applies one request to the copy and returns the ok bit it should produce.
  function automatic logic table_apply(input req_t r);
    int o, n, hit;
    logic [31:0] page, re;
    o = (r.kind == prt_pkg::OP_REMOVE_OWNER) ? owner_slot(r.creator) : owner_slot(r.owner);
    case (r.kind)
      prt_pkg::OP_INSERT: begin
        if (o >= 0) begin
          if (tbl_cnt[o] >= prt_pkg::MAX_REGIONS) return 1'b0;
        end else begin
          if (tbl_owners >= prt_pkg::MAX_OWNERS) return 1'b0;
          o = tbl_owners;
          tbl_owners = tbl_owners + 1;
          tbl_ids[o] = r.owner;
          tbl_cnt[o] = 0;
        end
        n = tbl_cnt[o];
        tbl_cnt[o] = n + 1;
        tbl_base[o][n] = r.rbase;
        tbl_size[o][n] = r.rsize;
        tbl_crea[o][n] = r.creator;
        return 1'b1;
      end
      prt_pkg::OP_QUERY: begin
        for (int i = 0; i < tbl_owners; i++) begin
          if (tbl_ids[i] != r.owner) continue;
          for (int j = 0; j < tbl_cnt[i]; j++)
            if (tbl_crea[i][j] == r.creator && r.rbase >= tbl_base[i][j] &&
                32'(r.rbase + r.rsize) <= 32'(tbl_base[i][j] + tbl_size[i][j]))
              return 1'b1;
        end
        return 1'b0;
      end
      prt_pkg::OP_REMOVE_OWNER: begin
        if (o < 0) return 1'b0;
        for (int i = o; i < tbl_owners - 1; i++) begin
          tbl_ids[i] = tbl_ids[i+1];
          tbl_cnt[i] = tbl_cnt[i+1];
          tbl_base[i] = tbl_base[i+1];
          tbl_size[i] = tbl_size[i+1];
          tbl_crea[i] = tbl_crea[i+1];
        end
        tbl_owners--;
        return 1'b1;
      end
      default: begin
        if (o < 0) return 1'b0;
        page = (r.sp & prt_pkg::PAGE_MASK) - r.span + prt_pkg::PAGE_SIZE;
        hit = -1;
        for (int j = 0; j < tbl_cnt[o] && hit < 0; j++) begin
          re = tbl_base[o][j] + tbl_size[o][j];
          if ((tbl_base[o][j] <= r.sp && re >= r.sp) ||
              (tbl_base[o][j] < 32'(r.bottom + r.span) && re > r.bottom) ||
              (tbl_base[o][j] < 32'(page + r.span) && re > page))
            hit = j;
        end
        if (hit < 0) return 1'b0;
        for (int j = hit; j < tbl_cnt[o] - 1; j++) begin
          tbl_base[o][j] = tbl_base[o][j+1];
          tbl_size[o][j] = tbl_size[o][j+1];
          tbl_crea[o][j] = tbl_crea[o][j+1];
        end
        tbl_cnt[o]--;
        return 1'b1;
      end
    endcase
  endfunction

  // Random 32-bit value biased toward extremes and a small address window.
  function automatic logic [31:0] rnd_addr();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 4096);
      1: return $urandom_range(0, 16);
      2: return $urandom();
      default: return 32'h0010_0000 + $urandom_range(0, 32'h4000);
    endcase
  endfunction

  // Random request; owners come mostly from a small pool so lists fill and empty.
  function automatic req_t rnd_req(input int pool);
    req_t r;
    r.kind = prt_pkg::op_t'($urandom_range(0, 9) < 4 ? prt_pkg::OP_INSERT :
                            $urandom_range(1, 3));
    r.rbase = rnd_addr();
    r.rsize = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'h2000);
    r.owner = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, pool);
    r.creator = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, pool);
    r.sp = rnd_addr();
    r.bottom = rnd_addr();
    r.span = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'h3000);
    r.want = -1;
    if (r.kind == prt_pkg::OP_QUERY && tbl_owners > 0 && $urandom_range(0, 1)) begin
      // Aim inside a stored region so that queries also hit.
      int o, j;
      o = $urandom_range(0, tbl_owners - 1);
      if (tbl_cnt[o] > 0) begin
        j = $urandom_range(0, tbl_cnt[o] - 1);
        r.owner = tbl_ids[o];
        r.creator = tbl_crea[o][j];
        r.rbase = tbl_base[o][j] + $urandom_range(0, 3);
        r.rsize = $urandom_range(0, 8);
      end
    end
    return r;
  endfunction

  // Offers one word; valid drops only when the sender takes a gap before the next one.
  task automatic send(input req_t r);
    int gap;
    logic predicted;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op <= r.kind;
    base <= r.rbase;
    size <= r.rsize;
    owner_id <= r.owner;
    creator_id <= r.creator;
    stack_ptr <= r.sp;
    stack_bottom <= r.bottom;
    stack_span <= r.span;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = table_apply(r);
    if (r.want >= 0 && predicted !== r.want[0])
      report($sformatf("predictor disagrees with directed row op %0d", r.kind));
    expected_ok.push_back(r.want >= 0 ? r.want[0] : predicted);
    @(negedge clk);
  endtask

  function automatic req_t row(input prt_pkg::op_t k, input logic [31:0] b, s, o, c,
                               input logic [31:0] sp, bt, sn, input int w);
    req_t r;
    r.kind = k; r.rbase = b; r.rsize = s; r.owner = o; r.creator = c;
    r.sp = sp; r.bottom = bt; r.span = sn; r.want = w;
    return r;
  endfunction

  // Sender: directed rows, a fill of both levels, emptying the table, then random requests.
  initial begin
    req_t rows [$];
    req_t r;
    rows = '{
      row(prt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0),
      row(prt_pkg::OP_REMOVE_OWNER, 0, 0, 0, 0, 0, 0, 0, 0),
      row(prt_pkg::OP_REMOVE_STACK, 0, 0, 0, 0, 0, 0, 0, 0),
      row(prt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          0, 0, 0, 1),
      row(prt_pkg::OP_INSERT, 0, 0, 0, 0, 0, 0, 0, 1),
      row(prt_pkg::OP_INSERT, 32'h1000, 32'h100, 5, 7, 0, 0, 0, 1),
      row(prt_pkg::OP_QUERY, 32'h1010, 32'h10, 5, 7, 0, 0, 0, 1),
      row(prt_pkg::OP_QUERY, 32'h1010, 32'h10, 5, 8, 0, 0, 0, 0),
      row(prt_pkg::OP_QUERY, 32'h1010, 32'h1000, 5, 7, 0, 0, 0, 0),
      row(prt_pkg::OP_QUERY, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, -1),
      row(prt_pkg::OP_QUERY, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, -1),
      row(prt_pkg::OP_INSERT, 32'h8000, 32'h2000, 5, 7, 0, 0, 0, 1),
      row(prt_pkg::OP_REMOVE_STACK, 0, 0, 5, 0, 32'h9123, 32'h4000_0000, 0, -1),
      row(prt_pkg::OP_REMOVE_STACK, 0, 0, 5, 0, 32'hF000_0000, 32'h0FF0, 32'h20, -1),
      row(prt_pkg::OP_REMOVE_STACK, 0, 0, 5, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, -1),
      row(prt_pkg::OP_REMOVE_STACK, 0, 0, 6, 0, 32'h1000, 0, 0, 0),
      row(prt_pkg::OP_REMOVE_OWNER, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 1),
      row(prt_pkg::OP_REMOVE_OWNER, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0),
      row(prt_pkg::OP_REMOVE_OWNER, 0, 0, 0, 5, 0, 0, 0, -1),
      row(prt_pkg::OP_REMOVE_OWNER, 0, 0, 0, 0, 0, 0, 0, -1)
    };
    tbl_owners = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send(rows[i]);

    // Fill one region list past full, then the owner table past full.
    for (int i = 0; i <= prt_pkg::MAX_REGIONS; i++)
      send(row(prt_pkg::OP_INSERT, i * 16, 16, 32'hA5A5_0000, i, 0, 0, 0,
               i < prt_pkg::MAX_REGIONS ? 1 : 0));
    for (int i = 1; i <= prt_pkg::MAX_OWNERS; i++)
      send(row(prt_pkg::OP_INSERT, 0, 8, i, 0, 0, 0, 0, i < prt_pkg::MAX_OWNERS ? 1 : 0));

    // Hold until the block has drained, then empty the table from the middle out.
    in_valid <= 1'b0;
    wait (expected_ok.size() == 0);
    @(negedge clk);
    for (int i = prt_pkg::MAX_OWNERS / 2; i > -prt_pkg::MAX_OWNERS; i--)
      send(row(prt_pkg::OP_REMOVE_OWNER, 0, 0, 0,
               i < 0 ? -i + prt_pkg::MAX_OWNERS / 2 : i, 0, 0, 0, -1));
    send(row(prt_pkg::OP_REMOVE_OWNER, 0, 0, 0, 32'hA5A5_0000, 0, 0, 0, -1));

    long_hold = 300;
    for (int i = 0; i < 1300; i++) begin
      r = rnd_req(i < 650 ? 12 : 80);
      send(r);
    end
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: random stalls, one long hold when asked.
  initial begin
    int wait_cycles;
    @(negedge clk);
    while (1) begin
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
      end
      wait_cycles = $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_ok.size() == 0)
        report("result word with nothing expected");
      else if (ok !== expected_ok.pop_front())
        report($sformatf("ok=%b differs from prediction", ok));
    end
  end

  initial begin
    wait (sender_done && expected_ok.size() == 0);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_ok.size() == 0)
      $display("[process_region_table_core] OK");
    else
      $display("[process_region_table_core] ERROR");
    $finish;
  end

  initial begin
    #10000000;
    $display("[process_region_table_core] ERROR");
    $finish;
  end
endmodule
